@@ rtl/wvc_pkg.sv @@
// ----------------------------------------------------------------------------
// wvc_pkg
// Shared types, widths and codes of the window variance classifier.
// ----------------------------------------------------------------------------
package wvc_pkg;

    localparam int WINDOW_DEFAULT = 40;

    // Field and accumulator widths.
    localparam int DIST_W  = 9;
    localparam int CNT_W   = 6;
    localparam int SUM_W   = 15;
    localparam int SQ_W    = 24;
    localparam int VLIM_W  = 16;
    localparam int MEAN_W  = 13;
    localparam int VAR_W   = 21;
    localparam int PROD_W  = 30;
    localparam int DEN_W   = 12;
    localparam int THR_W   = 28;

    // Iterative divider: dividend is sixteen times the reading sum or the deviation term.
    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 12;
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

    localparam logic [VAR_W-1:0] VAR_SAT = {VAR_W{1'b1}};

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DROP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_LIM  = 2'd2;

    localparam logic [DIST_W-1:0] DIST_LIM_RESET = 9'd50;
    localparam logic [CNT_W-1:0]  MAX_DROP_RESET = 6'd12;
    localparam logic [VLIM_W-1:0] VAR_LIM_RESET  = 16'd128;

    typedef enum logic {
        DIV_MEAN,
        DIV_VAR
    } t_div_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_DEV,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_VAR,
        ST_VAR_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic     accum;
        logic     prod;
        logic     dev;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_mean;
        logic     cap_var;
        logic     emit;
        logic     clear;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic div_done;
    } t_dp_status;

endpackage

@@ rtl/wvc_divider.sv @@
// ----------------------------------------------------------------------------
// wvc_divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wvc_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [wvc_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [wvc_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                               o_done,
    output logic [wvc_pkg::DIVIDEND_W-1:0]     o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [wvc_pkg::STEP_W-1:0]         r_cnt;
    logic [wvc_pkg::DIVISOR_W-1:0]      r_rem;
    logic [wvc_pkg::DIVISOR_W-1:0]      r_div;
    logic [wvc_pkg::DIVIDEND_W-1:0]     r_quo;

    logic [wvc_pkg::DIVISOR_W:0]        trial;
    logic [wvc_pkg::DIVISOR_W:0]        diff;
    logic                               fits;
    logic [wvc_pkg::DIVISOR_W-1:0]      n_rem;
    logic [wvc_pkg::DIVIDEND_W-1:0]     n_quo;

    always_comb begin
        trial = {r_rem, r_quo[wvc_pkg::DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
        // The remainder stays below the divisor, so either choice fits its width.
        n_rem = fits ? diff[wvc_pkg::DIVISOR_W-1:0] : trial[wvc_pkg::DIVISOR_W-1:0];
        n_quo = {r_quo[wvc_pkg::DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= wvc_pkg::STEP_W'(wvc_pkg::DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wvc_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/wvc_datapath.sv @@
// ----------------------------------------------------------------------------
// wvc_datapath
// Configuration registers, window accumulators, statistics and result registers.
// ----------------------------------------------------------------------------
module wvc_datapath #(
    parameter int WINDOW = wvc_pkg::WINDOW_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [wvc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wvc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [wvc_pkg::DIST_W-1:0]         i_distance_cm,
    input  logic                               i_no_echo,
    input  wvc_pkg::t_dp_cmd                   i_cmd,
    output wvc_pkg::t_dp_status                o_status,
    output logic                               o_result_valid,
    output logic                               o_is_foam,
    output logic [wvc_pkg::CNT_W-1:0]          o_valid_count,
    output logic [wvc_pkg::CNT_W-1:0]          o_dropout_count,
    output logic [wvc_pkg::MEAN_W-1:0]         o_mean_q4,
    output logic [wvc_pkg::VAR_W-1:0]          o_variance_q4
);

    // Configuration.
    logic [wvc_pkg::DIST_W-1:0]     r_dist_limit;
    logic [wvc_pkg::CNT_W-1:0]      r_max_drop;
    logic [wvc_pkg::VLIM_W-1:0]     r_var_lim;

    // Window accumulators.
    logic [wvc_pkg::CNT_W-1:0]      r_index;
    logic [wvc_pkg::CNT_W-1:0]      r_acc;
    logic [wvc_pkg::CNT_W-1:0]      r_rej;
    logic [wvc_pkg::SUM_W-1:0]      r_sum;
    logic [wvc_pkg::SQ_W-1:0]       r_sq;

    // End-of-window statistics.
    logic [wvc_pkg::PROD_W-1:0]     r_nq;
    logic [wvc_pkg::PROD_W-1:0]     r_ss;
    logic [wvc_pkg::DEN_W-1:0]      r_den;
    logic [wvc_pkg::DIVIDEND_W-1:0] r_dev16;
    logic [wvc_pkg::THR_W-1:0]      r_thr;
    logic [wvc_pkg::MEAN_W-1:0]     r_mean;
    logic [wvc_pkg::VAR_W-1:0]      r_var;

    // Result registers.
    logic                           r_out_valid;
    logic                           r_out_foam;
    logic [wvc_pkg::CNT_W-1:0]      r_out_acc;
    logic [wvc_pkg::CNT_W-1:0]      r_out_rej;
    logic [wvc_pkg::MEAN_W-1:0]     r_out_mean;
    logic [wvc_pkg::VAR_W-1:0]      r_out_var;

    logic                           dropout;
    logic [2*wvc_pkg::DIST_W-1:0]   dist_sq;
    logic [wvc_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [wvc_pkg::DIVISOR_W-1:0]  div_divisor;
    logic                           div_done;
    logic [wvc_pkg::DIVIDEND_W-1:0] div_quotient;
    logic                           foam;

    assign dropout = i_no_echo || (i_distance_cm > r_dist_limit);
    assign dist_sq = (2*wvc_pkg::DIST_W)'(i_distance_cm) * (2*wvc_pkg::DIST_W)'(i_distance_cm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_limit <= wvc_pkg::DIST_LIM_RESET;
            r_max_drop   <= wvc_pkg::MAX_DROP_RESET;
            r_var_lim    <= wvc_pkg::VAR_LIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wvc_pkg::CFG_DIST_LIM: r_dist_limit <= i_cfg_data[wvc_pkg::DIST_W-1:0];
                wvc_pkg::CFG_MAX_DROP: r_max_drop   <= i_cfg_data[wvc_pkg::CNT_W-1:0];
                wvc_pkg::CFG_VAR_LIM:  r_var_lim    <= i_cfg_data[wvc_pkg::VLIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // No accumulator can wrap while the window holds at most 63 readings; the block does not enforce that bound.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_index <= '0;
            r_acc   <= '0;
            r_rej   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end else if (i_cmd.accum) begin
            r_index <= r_index + 1'b1;
            if (dropout) begin
                r_rej <= r_rej + 1'b1;
            end else begin
                r_acc <= r_acc + 1'b1;
                r_sum <= r_sum + wvc_pkg::SUM_W'(i_distance_cm);
                r_sq  <= r_sq + wvc_pkg::SQ_W'(dist_sq);
            end
        end
    end

    assign o_status.last     = (r_index == wvc_pkg::CNT_W'(WINDOW - 1));
    assign o_status.div_done = div_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod) begin
            r_nq  <= wvc_pkg::PROD_W'(r_acc) * wvc_pkg::PROD_W'(r_sq);
            r_ss  <= wvc_pkg::PROD_W'(r_sum) * wvc_pkg::PROD_W'(r_sum);
            // With no valid reading n-1 wraps, but n itself is zero.
            r_den <= wvc_pkg::DEN_W'(r_acc) * wvc_pkg::DEN_W'(r_acc - 1'b1);
        end
        if (i_cmd.dev) begin
            r_dev16 <= (r_nq > r_ss) ? {r_nq - r_ss, 4'b0000} : '0;
            r_thr   <= wvc_pkg::THR_W'(r_var_lim) * wvc_pkg::THR_W'(r_den);
        end
        if (i_cmd.cap_mean) begin
            r_mean <= div_quotient[wvc_pkg::MEAN_W-1:0];
        end
        if (i_cmd.cap_var) begin
            r_var <= (div_quotient > wvc_pkg::DIVIDEND_W'(wvc_pkg::VAR_SAT))
                   ? wvc_pkg::VAR_SAT : div_quotient[wvc_pkg::VAR_W-1:0];
        end
    end

    always_comb begin
        if (i_cmd.div_sel == wvc_pkg::DIV_MEAN) begin
            div_dividend = wvc_pkg::DIVIDEND_W'({r_sum, 4'b0000});
            div_divisor  = wvc_pkg::DIVISOR_W'(r_acc);
        end else begin
            div_dividend = r_dev16;
            div_divisor  = r_den;
        end
    end

    wvc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // The variance test only counts with at least two valid readings.
    assign foam = (r_rej > r_max_drop)
               || ((r_acc > wvc_pkg::CNT_W'(1)) && (r_dev16 > wvc_pkg::DIVIDEND_W'(r_thr)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_foam <= foam;
            r_out_acc  <= r_acc;
            r_out_rej  <= r_rej;
            r_out_mean <= (r_acc == '0) ? '0 : r_mean;
            r_out_var  <= (r_acc > wvc_pkg::CNT_W'(1)) ? r_var : '0;
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_is_foam       = r_out_foam;
    assign o_valid_count   = r_out_acc;
    assign o_dropout_count = r_out_rej;
    assign o_mean_q4       = r_out_mean;
    assign o_variance_q4   = r_out_var;

endmodule

@@ rtl/wvc_controller.sv @@
// ----------------------------------------------------------------------------
// wvc_controller
// Sequences accumulation and the end-of-window statistics.
// ----------------------------------------------------------------------------
module wvc_controller (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  wvc_pkg::t_dp_status     i_status,
    output logic                    o_busy,
    output wvc_pkg::t_dp_cmd        o_cmd
);

    wvc_pkg::t_state r_state;
    wvc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wvc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = wvc_pkg::DIV_MEAN;
        o_busy        = 1'b1;
        unique case (r_state)
            wvc_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accum = 1'b1;
                    if (i_status.last) begin
                        n_state = wvc_pkg::ST_PROD;
                    end
                end
            end
            wvc_pkg::ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = wvc_pkg::ST_DEV;
            end
            wvc_pkg::ST_DEV: begin
                o_cmd.dev = 1'b1;
                n_state   = wvc_pkg::ST_MEAN;
            end
            wvc_pkg::ST_MEAN: begin
                o_cmd.div_start = 1'b1;
                n_state         = wvc_pkg::ST_MEAN_WAIT;
            end
            wvc_pkg::ST_MEAN_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.cap_mean = 1'b1;
                    n_state        = wvc_pkg::ST_VAR;
                end
            end
            wvc_pkg::ST_VAR: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wvc_pkg::DIV_VAR;
                n_state         = wvc_pkg::ST_VAR_WAIT;
            end
            wvc_pkg::ST_VAR_WAIT: begin
                o_cmd.div_sel = wvc_pkg::DIV_VAR;
                if (i_status.div_done) begin
                    o_cmd.cap_var = 1'b1;
                    n_state       = wvc_pkg::ST_EMIT;
                end
            end
            wvc_pkg::ST_EMIT: begin
                o_cmd.emit  = 1'b1;
                o_cmd.clear = 1'b1;
                n_state     = wvc_pkg::ST_IDLE;
            end
            default: begin
                n_state = wvc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/window_variance_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// window_variance_classifier_unit
// Range readings in, one mean/variance/class result per window out.
// ----------------------------------------------------------------------------
// Each reading is taken in the cycle that start is high while idle; busy stays low between readings.
// After the last reading of a window, busy stays high through the product and
// deviation states, then two 34-step divisions (mean, variance) on one shared
// one-bit-per-cycle divider, then the result state. The result strobe is high
// for one cycle, the first cycle busy is low again; it cannot be stalled.
// Synchronous reset clears the window and restores the register defaults.
module window_variance_classifier_unit #(
    parameter int WINDOW = wvc_pkg::WINDOW_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [wvc_pkg::DIST_W-1:0]         i_distance_cm,
    input  logic                               i_no_echo,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wvc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wvc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_result_valid,
    output logic                               o_is_foam,
    output logic [wvc_pkg::CNT_W-1:0]          o_valid_count,
    output logic [wvc_pkg::CNT_W-1:0]          o_dropout_count,
    output logic [wvc_pkg::MEAN_W-1:0]         o_mean_q4,
    output logic [wvc_pkg::VAR_W-1:0]          o_variance_q4
);

    wvc_pkg::t_dp_cmd    cmd;
    wvc_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    wvc_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    wvc_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_distance_cm   (i_distance_cm),
        .i_no_echo       (i_no_echo),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_result_valid  (o_result_valid),
        .o_is_foam       (o_is_foam),
        .o_valid_count   (o_valid_count),
        .o_dropout_count (o_dropout_count),
        .o_mean_q4       (o_mean_q4),
        .o_variance_q4   (o_variance_q4)
    );

endmodule

@@ rtl/wvc_checker.sv @@
// ----------------------------------------------------------------------------
// wvc_checker
// Port-level checks of the classifier's result behavior.
// ----------------------------------------------------------------------------
module wvc_checker #(
    parameter int WINDOW = wvc_pkg::WINDOW_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               busy,
    input  logic                               o_result_valid,
    input  logic [wvc_pkg::CNT_W-1:0]          o_valid_count,
    input  logic [wvc_pkg::CNT_W-1:0]          o_dropout_count,
    input  logic [wvc_pkg::MEAN_W-1:0]         o_mean_q4,
    input  logic [wvc_pkg::VAR_W-1:0]          o_variance_q4
);

    // The result strobe must never be high in two consecutive cycles.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // Every reading of the window is counted exactly once.
    a_counts_cover_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            ((7'(o_valid_count) + 7'(o_dropout_count)) == 7'(WINDOW)))
        else $error("valid and dropout counts do not add up to the window");

    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while the unit is still busy");

    a_mean_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_valid_count == '0)) |-> (o_mean_q4 == '0))
        else $error("nonzero mean without valid readings");

    a_var_few: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_valid_count <= wvc_pkg::CNT_W'(1))) |->
            (o_variance_q4 == '0))
        else $error("nonzero variance with at most one valid reading");

endmodule

bind window_variance_classifier_unit wvc_checker #(
    .WINDOW (WINDOW)
) u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_result_valid  (o_result_valid),
    .o_valid_count   (o_valid_count),
    .o_dropout_count (o_dropout_count),
    .o_mean_q4       (o_mean_q4),
    .o_variance_q4   (o_variance_q4)
);
